// File: hw/rtl/bbc_pkg.sv
// Bounce burst classifier package: sizes, result kind codes, readout states
// and the struct that carries per-beat tracking results to the readout.
// No dependencies.
package bbc_pkg;

   // edge stamp storage
   localparam int EDGE_SLOTS   = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int ADDR_W       = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
   localparam int COUNT_W      = $clog2(EDGE_SLOTS + 1);
   localparam int EMIT_MAX     = (EDGE_SLOTS < RESULT_LIMIT) ? EDGE_SLOTS : RESULT_LIMIT;

   // field widths
   localparam int GAP_W   = 20;
   localparam int WORD_W  = 32;
   localparam int KIND_W  = 3;
   localparam int RSP_DATA_W = 6 * WORD_W;
   localparam int REQ_DATA_W = 8;

   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(30000);

   // burst_kind codes
   localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TAP     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAN   = 3'd4;

   typedef enum logic [2:0] {
      RO_IDLE,
      RO_CLEAN,
      RO_FIRST,
      RO_TAKE_FIRST,
      RO_TAKE_SPAN,
      RO_ISSUE,
      RO_LOAD
   } ro_state_type;

   // tracker -> readout
   typedef struct packed {
      logic                close;        // burst closed on this beat
      logic                clean;        // clean release on this beat
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   count;        // edges in the closed burst
      logic [COUNT_W-1:0]  stored;       // stamps held in the RAM
      logic [WORD_W-1:0]   press_index;  // live counter
      logic [WORD_W-1:0]   all_edges;    // live counter
   } bbc_track_type;

endpackage

// File: hw/rtl/bbc_edge_ram.sv
// Edge stamp RAM: one write port, one read port, registered read data.
// Depends on bbc_pkg.
module bbc_edge_ram
   import bbc_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [EDGE_SLOTS];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bbc_tracker.sv
// Per-tick tracker: edge capture, burst close check, classification,
// counters and the gap register. Drives the edge RAM write port.
// Depends on bbc_pkg.
module bbc_tracker
   import bbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic              pin_level,
   input  logic              gap_we,
   input  logic [GAP_W-1:0]  gap_data,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_addr,
   output logic [WORD_W-1:0] mem_data,
   output bbc_track_type     trk
);

   logic              prev_ff,    prev_in;
   logic [WORD_W-1:0] tick_ff,    tick_in;
   logic [WORD_W-1:0] count_ff,   count_in;
   logic [WORD_W-1:0] last_ff,    last_in;
   logic [WORD_W-1:0] total_ff,   total_in;
   logic [WORD_W-1:0] press_ff,   press_in;
   logic              pressed_ff, pressed_in;
   logic [WORD_W-1:0] high_ff,    high_in;
   logic [GAP_W-1:0]  gap_ff;

   logic              falling;
   logic              low;
   logic [WORD_W-1:0] count_edge;
   logic [WORD_W-1:0] gap_ext;
   logic              quiet_burst;
   logic              quiet_high;
   logic              close;
   logic              clean;
   logic              pending;
   logic [KIND_W-1:0] kind;

   assign low         = ~pin_level;
   assign falling     = prev_ff & low;
   assign count_edge  = count_ff + WORD_W'(1);
   assign gap_ext     = WORD_W'(gap_ff);
   assign quiet_burst = (tick_ff - last_ff) > gap_ext;
   assign quiet_high  = (tick_ff - high_ff) > gap_ext;

   // a falling edge sets the last stamp to now, so it never closes a burst
   assign close   = beat & ~falling & (count_ff != '0) & quiet_burst;
   assign pending = falling ? (count_edge != '0) : ((count_ff != '0) & ~close);
   assign clean   = beat & ~close & pressed_ff & ~low & ~pending & quiet_high;

   // classification
   always_comb begin
      if (low && pressed_ff) begin
         kind = KIND_HOLD;
      end else if (low) begin
         kind = KIND_PRESS;
      end else if (pressed_ff) begin
         kind = KIND_RELEASE;
      end else begin
         kind = KIND_TAP;
      end
   end

   // next state of the tick registers
   always_comb begin
      prev_in    = prev_ff;
      tick_in    = tick_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      total_in   = total_ff;
      press_in   = press_ff;
      pressed_in = pressed_ff;
      high_in    = high_ff;
      if (beat) begin
         prev_in = pin_level;
         tick_in = tick_ff + WORD_W'(1);
         if (falling) begin
            count_in = count_edge;
            last_in  = tick_ff;
            total_in = total_ff + WORD_W'(1);
         end
         if (close) begin
            count_in = '0;
            high_in  = tick_ff;
            if (kind == KIND_PRESS || kind == KIND_TAP) begin
               press_in = press_ff + WORD_W'(1);
            end
            if (kind == KIND_PRESS) begin
               pressed_in = 1'b1;
            end else if (kind == KIND_RELEASE) begin
               pressed_in = 1'b0;
            end
         end else if (pressed_ff && !low && !pending) begin
            if (quiet_high) begin
               pressed_in = 1'b0;
            end
         end else begin
            high_in = tick_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b1;
         tick_ff    <= '0;
         count_ff   <= '0;
         last_ff    <= '0;
         total_ff   <= '0;
         press_ff   <= '0;
         pressed_ff <= 1'b0;
         high_ff    <= '0;
      end else begin
         prev_ff    <= prev_in;
         tick_ff    <= tick_in;
         count_ff   <= count_in;
         last_ff    <= last_in;
         total_ff   <= total_in;
         press_ff   <= press_in;
         pressed_ff <= pressed_in;
         high_ff    <= high_in;
      end
   end

   // gap register
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (gap_we) begin
         gap_ff <= gap_data;
      end
   end

   // stamp store for the first slots of a burst
   assign mem_we   = beat & falling & (count_ff < WORD_W'(EDGE_SLOTS));
   assign mem_addr = count_ff[ADDR_W-1:0];
   assign mem_data = tick_ff;

   // report to readout
   always_comb begin
      trk.close       = close;
      trk.clean       = clean;
      trk.kind        = clean ? KIND_CLEAN : kind;
      trk.count       = count_ff;
      trk.stored      = (count_ff < WORD_W'(EDGE_SLOTS)) ? count_ff[COUNT_W-1:0]
                                                         : COUNT_W'(EDGE_SLOTS);
      trk.press_index = press_ff;
      trk.all_edges   = total_ff;
   end

   // a stamp is never written on the beat that closes a burst
   a_no_write_on_close: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !close) else $error("stamp write on closing beat");

   // a clean release leaves the button released
   a_clean_releases: assert property (@(posedge clock) disable iff (reset)
      clean |=> !pressed_ff) else $error("pressed after clean release");

   // the closing beat empties the burst
   a_close_empties: assert property (@(posedge clock) disable iff (reset)
      close |=> (count_ff == '0)) else $error("burst still open after close");

endmodule

// File: hw/rtl/bbc_readout.sv
// Burst readout sequencer: walks the edge RAM after a burst closes, or takes a
// clean release, and fills the result output register. Depends on bbc_pkg.
module bbc_readout
   import bbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  bbc_track_type         trk,
   input  logic [WORD_W-1:0]     rd_data,
   output logic                  rd_en,
   output logic [ADDR_W-1:0]     rd_addr,
   output logic                  idle,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   ro_state_type state_ff, state_in;

   logic [KIND_W-1:0]  kind_ff,     kind_in;
   logic [WORD_W-1:0]  count_ff,    count_in;
   logic [COUNT_W-1:0] stored_ff,   stored_in;
   logic [ADDR_W-1:0]  last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0]  idx_ff,      idx_in;
   logic [WORD_W-1:0]  first_ff,    first_in;
   logic [WORD_W-1:0]  span_ff,     span_in;

   // output register
   logic               valid_ff,  valid_in;
   logic [KIND_W-1:0]  o_kind_ff, o_kind_in;
   logic [WORD_W-1:0]  o_press_ff, o_press_in;
   logic [WORD_W-1:0]  o_edges_ff, o_edges_in;
   logic [WORD_W-1:0]  o_off_ff,   o_off_in;
   logic [WORD_W-1:0]  o_span_ff,  o_span_in;
   logic [WORD_W-1:0]  o_miss_ff,  o_miss_in;
   logic [WORD_W-1:0]  o_total_ff, o_total_in;
   logic               o_last_ff,  o_last_in;

   logic               out_free;
   logic               load;
   logic               last_beat;
   logic [COUNT_W-1:0] emit;
   logic [ADDR_W-1:0]  span_addr;

   assign out_free  = ~valid_ff | rsp_tready;
   assign last_beat = (idx_ff == last_idx_ff);
   assign emit      = (trk.stored < COUNT_W'(EMIT_MAX)) ? trk.stored : COUNT_W'(EMIT_MAX);
   assign span_addr = ADDR_W'(stored_ff - COUNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RO_IDLE: begin
            if (trk.close) begin
               state_in = RO_FIRST;
            end else if (trk.clean) begin
               state_in = RO_CLEAN;
            end
         end
         RO_CLEAN: begin
            if (out_free) begin
               state_in = RO_IDLE;
            end
         end
         RO_FIRST:      state_in = RO_TAKE_FIRST;
         RO_TAKE_FIRST: state_in = RO_TAKE_SPAN;
         RO_TAKE_SPAN:  state_in = RO_LOAD;
         RO_ISSUE:      state_in = RO_LOAD;
         RO_LOAD: begin
            if (out_free) begin
               state_in = last_beat ? RO_IDLE : RO_ISSUE;
            end
         end
         default: state_in = RO_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      load        = 1'b0;
      kind_in     = kind_ff;
      count_in    = count_ff;
      stored_in   = stored_ff;
      last_idx_in = last_idx_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      span_in     = span_ff;
      unique case (state_ff)
         RO_IDLE: begin
            if (trk.close || trk.clean) begin
               kind_in     = trk.kind;
               count_in    = trk.count;
               stored_in   = trk.stored;
               last_idx_in = ADDR_W'(emit - COUNT_W'(1));
               idx_in      = '0;
            end
         end
         RO_CLEAN: load = out_free;
         RO_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         RO_TAKE_FIRST: begin
            first_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = span_addr;
         end
         RO_TAKE_SPAN: begin
            span_in = rd_data - first_ff;
            rd_en   = 1'b1;
         end
         RO_ISSUE: rd_en = 1'b1;
         RO_LOAD: begin
            load = out_free;
            if (out_free) begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         default: ;
      endcase
   end

   // output register contents
   always_comb begin
      valid_in   = valid_ff & ~rsp_tready;
      o_kind_in  = o_kind_ff;
      o_press_in = o_press_ff;
      o_edges_in = o_edges_ff;
      o_off_in   = o_off_ff;
      o_span_in  = o_span_ff;
      o_miss_in  = o_miss_ff;
      o_total_in = o_total_ff;
      o_last_in  = o_last_ff;
      if (load) begin
         valid_in   = 1'b1;
         o_kind_in  = kind_ff;
         o_press_in = trk.press_index;
         o_total_in = trk.all_edges;
         if (state_ff == RO_CLEAN) begin
            o_edges_in = '0;
            o_off_in   = '0;
            o_span_in  = '0;
            o_miss_in  = '0;
            o_last_in  = 1'b1;
         end else begin
            o_edges_in = count_ff;
            o_off_in   = rd_data - first_ff;
            o_span_in  = span_ff;
            o_miss_in  = count_ff - WORD_W'(stored_ff);
            o_last_in  = last_beat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RO_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      count_ff    <= count_in;
      stored_ff   <= stored_in;
      last_idx_ff <= last_idx_in;
      idx_ff      <= idx_in;
      first_ff    <= first_in;
      span_ff     <= span_in;
      o_kind_ff   <= o_kind_in;
      o_press_ff  <= o_press_in;
      o_edges_ff  <= o_edges_in;
      o_off_ff    <= o_off_in;
      o_span_ff   <= o_span_in;
      o_miss_ff   <= o_miss_in;
      o_total_ff  <= o_total_in;
      o_last_ff   <= o_last_in;
   end

   assign idle       = (state_ff == RO_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {o_total_ff, o_miss_ff, o_span_ff, o_off_ff, o_edges_ff, o_press_ff};

   // the final beat of a run returns the sequencer to idle
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load && o_last_in) |=> (state_ff == RO_IDLE))
      else $error("run did not end after last beat");

   // the walk never passes the last emitted slot
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RO_LOAD || state_ff == RO_ISSUE) |-> (idx_ff <= last_idx_ff))
      else $error("readout index past last slot");

   // nothing new reaches the output register while idle
   a_no_load_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RO_IDLE) |-> !load) else $error("output load while idle");

endmodule

// File: hw/rtl/bounce_burst_classifier_core.sv
// Bounce burst classifier top level: stream ports, gap register port,
// tracker, edge stamp RAM and readout. Depends on bbc_pkg and submodules.
//
//   channel  direction  beat condition          payload
//   req_     in         req_tvalid & tready     tdata[0] pin_level
//   rsp_     out        rsp_tvalid & tready     tdata 6x32, tuser kind, tlast
//   csr_     in         csr_valid & csr_ready   csr_data burst_gap_ticks
//
// One pin sample per cycle is taken while no report is being read out.
// A closed burst with n results holds the input off while RO_FIRST, RO_TAKE_FIRST
// and RO_TAKE_SPAN fetch the first and last stamps (RO_TAKE_SPAN also reads slot 0),
// then RO_LOAD takes the first result and RO_ISSUE and RO_LOAD each further one through
// the single edge RAM read port (longer if rsp_tready is low); a clean release holds
// it off for its one output load plus output stall.
// Reset is synchronous; the edge RAM is not cleared and needs no sweep.
// csr_ready is always high.
module bounce_burst_classifier_core
   import bbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] pin_level, rest zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // press_index, burst_edges, edge_offset,
                                              // burst_span, edges_not_stored, all_edges
   output logic [KIND_W-1:0]     rsp_tuser,   // burst_kind
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [GAP_W-1:0]      csr_data     // burst_gap_ticks
);

   logic              beat;
   logic              idle;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   bbc_track_type     trk;

   assign req_tready = idle;
   assign beat       = req_tvalid & idle;
   assign csr_ready  = 1'b1;

   bbc_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .pin_level (req_tdata[0]),
      .gap_we    (csr_valid),
      .gap_data  (csr_data),
      .mem_we    (mem_we),
      .mem_addr  (mem_waddr),
      .mem_data  (mem_wdata),
      .trk       (trk)
   );

   bbc_edge_ram u_edge_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bbc_readout u_readout (
      .clock      (clock),
      .reset      (reset),
      .trk        (trk),
      .rd_data    (rd_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
